// File: rtl/sls_pkg.sv
// Shared types and constants for the sprite layer sort and batching core.
`default_nettype none
package sls_pkg;

	localparam int MAX_SPRITES    = 64;
	localparam int SLOT_W         = 6;
	localparam int CNT_W          = $clog2(MAX_SPRITES + 1);
	localparam int KEY_W          = 32;
	localparam int TEX_W          = 16;
	localparam int IDX_W          = 9;
	localparam logic [IDX_W-1:0] IDX_PER_SPRITE = IDX_W'(6);

	typedef struct packed {
		logic [KEY_W-1:0]  key;
		logic [TEX_W-1:0]  tex;
		logic [SLOT_W-1:0] slot;
	} sprite_t;

	typedef struct packed {
		logic    valid;
		sprite_t data;
	} rec_t;

	typedef struct packed {
		logic load;
		logic shift_out;
	} cell_ctrl_t;

endpackage
`default_nettype wire

// File: rtl/sprite_layer_sort_and_batching_core.sv
// Top level: sprite loading, insertion-sorting cell chain and batched result emit.
//
// Usage: sprite records arrive on the sprite channel (sprite_valid/sprite_stall),
// one transfer per cycle while loading. Each record is inserted into a chain
// of sorter cells, so the chain is always ordered by layer, then order_key,
// with ties in arrival order. Records beyond 64 are dropped and the frame's
// results carry overflow = 1.
// The transfer carrying last starts the emit: sprite_stall goes high and the
// chain shifts one record per cycle towards cell 0 into the result register
// while result_stall is low. result_valid rises once the state has moved to
// emit and the first record sits in the result register, then one result per
// cycle follows while result_stall is low; a frame is fully loaded before it emits.
// When result_stall is high the result register holds and the chain waits.
// The next frame may load as soon as the final result sits in the register.
// After reset the chain is empty and the block is ready at once.
`default_nettype none
module sprite_layer_sort_and_batching_core (
	input  wire                       clk,
	input  wire                       arst_n,
	input  wire                       sprite_valid,
	output logic                      sprite_stall,
	input  wire signed [15:0]         layer,
	input  wire signed [15:0]         order_key,
	input  wire [15:0]                texture_id,
	input  wire                       last,
	output logic                      result_valid,
	input  wire                       result_stall,
	output logic [5:0]                source_slot,
	output logic [5:0]                dest_slot,
	output logic                      batch_close,
	output logic [5:0]                batch_number,
	output logic [5:0]                batch_first,
	output logic [8:0]                index_count,
	output logic                      overflow,
	output logic                      final_res
);
	import sls_pkg::*;

	typedef enum logic {ST_LOAD, ST_EMIT} state_t;

	state_t            state_q;
	logic [CNT_W-1:0]  count_q;
	logic              dropped_q;
	logic [CNT_W-1:0]  k_q;
	logic [SLOT_W-1:0] batch_q;
	logic [SLOT_W-1:0] first_q;
	logic [CNT_W-1:0]  run_q;

	logic              out_valid_q;
	logic [5:0]        source_slot_q;
	logic [5:0]        dest_slot_q;
	logic              batch_close_q;
	logic [5:0]        batch_number_q;
	logic [5:0]        batch_first_q;
	logic [8:0]        index_count_q;
	logic              overflow_q;
	logic              final_res_q;

	rec_t              cell_rec [MAX_SPRITES];
	logic              cell_gt  [MAX_SPRITES];
	rec_t              new_rec;
	cell_ctrl_t        ctrl;

	logic              accept;
	logic              full;
	logic              emit;
	logic              k_last;
	logic              batch_end;
	logic [CNT_W-1:0]  k_next;
	logic [CNT_W-1:0]  run_inc;
	logic [IDX_W-1:0]  run_idx;

	assign sprite_stall = (state_q != ST_LOAD);
	assign accept       = sprite_valid && !sprite_stall;
	assign full         = (count_q == CNT_W'(MAX_SPRITES));

	assign new_rec.valid     = 1'b1;
	assign new_rec.data.key  = {~layer[15], layer[14:0], ~order_key[15], order_key[14:0]};
	assign new_rec.data.tex  = texture_id;
	assign new_rec.data.slot = count_q[SLOT_W-1:0];

	assign emit      = (state_q == ST_EMIT) && (!out_valid_q || !result_stall);
	assign k_next    = k_q + CNT_W'(1);
	assign k_last    = (k_next == count_q);
	assign batch_end = k_last || (cell_rec[1].data.tex != cell_rec[0].data.tex);
	assign run_inc   = run_q + CNT_W'(1);
	assign run_idx   = IDX_W'(IDX_W'(run_inc) * IDX_PER_SPRITE);

	assign ctrl.load      = accept && !full;
	assign ctrl.shift_out = emit;

	for (genvar i = 0; i < MAX_SPRITES; i++) begin : g_cell
		rec_t prev_r;
		rec_t next_r;
		logic prev_g;

		if (i == 0) begin : g_head
			assign prev_r = '0;
			assign prev_g = 1'b0;
		end else begin : g_body
			assign prev_r = cell_rec[i-1];
			assign prev_g = cell_gt[i-1];
		end

		if (i == MAX_SPRITES - 1) begin : g_tail
			assign next_r = '0;
		end else begin : g_mid
			assign next_r = cell_rec[i+1];
		end

		sls_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.ctrl     (ctrl),
			.new_rec  (new_rec),
			.prev_rec (prev_r),
			.prev_gt  (prev_g),
			.next_rec (next_r),
			.rec      (cell_rec[i]),
			.gt       (cell_gt[i])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_LOAD;
			count_q     <= '0;
			dropped_q   <= 1'b0;
			k_q         <= '0;
			batch_q     <= '0;
			first_q     <= '0;
			run_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (!result_stall) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_LOAD: begin
					if (accept) begin
						if (full) begin
							dropped_q <= 1'b1;
						end else begin
							count_q <= count_q + CNT_W'(1);
						end
						if (last) begin
							state_q <= ST_EMIT;
							k_q     <= '0;
							batch_q <= '0;
							first_q <= '0;
							run_q   <= '0;
						end
					end
				end
				ST_EMIT: begin
					if (emit) begin
						k_q         <= k_next;
						if (batch_end) begin
							batch_q <= batch_q + SLOT_W'(1);
							first_q <= k_next[SLOT_W-1:0];
							run_q   <= '0;
						end else begin
							run_q   <= run_inc;
						end
						if (k_last) begin
							state_q   <= ST_LOAD;
							count_q   <= '0;
							dropped_q <= 1'b0;
						end
					end
				end
				default: state_q <= ST_LOAD;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			source_slot_q  <= cell_rec[0].data.slot;
			dest_slot_q    <= k_q[SLOT_W-1:0];
			batch_close_q  <= batch_end;
			batch_number_q <= batch_q;
			batch_first_q  <= first_q;
			index_count_q  <= batch_end ? run_idx : '0;
			overflow_q     <= dropped_q;
			final_res_q    <= k_last;
		end
	end

	assign result_valid = out_valid_q;
	assign source_slot  = source_slot_q;
	assign dest_slot    = dest_slot_q;
	assign batch_close  = batch_close_q;
	assign batch_number = batch_number_q;
	assign batch_first  = batch_first_q;
	assign index_count  = index_count_q;
	assign overflow     = overflow_q;
	assign final_res    = final_res_q;

endmodule
`default_nettype wire

// File: rtl/sls_cell.sv
// One sorter cell: holds a sprite record, inserts in key order, shifts out towards cell 0.
`default_nettype none
module sls_cell (
	input  wire                 clk,
	input  wire                 arst_n,
	input  sls_pkg::cell_ctrl_t ctrl,
	input  sls_pkg::rec_t       new_rec,
	input  sls_pkg::rec_t       prev_rec,
	input  wire                 prev_gt,
	input  sls_pkg::rec_t       next_rec,
	output sls_pkg::rec_t       rec,
	output logic                gt
);
	import sls_pkg::*;

	logic    valid_q;
	sprite_t data_q;
	logic    take_new;
	logic    take_prev;

	// strict compare keeps equal keys in arrival order
	assign gt        = !valid_q || (data_q.key > new_rec.data.key);
	assign take_new  = ctrl.load && gt && !prev_gt;
	assign take_prev = ctrl.load && gt && prev_gt;
	assign rec       = '{valid: valid_q, data: data_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (ctrl.shift_out) begin
			valid_q <= next_rec.valid;
		end else if (take_new) begin
			valid_q <= 1'b1;
		end else if (take_prev) begin
			valid_q <= prev_rec.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.shift_out) begin
			data_q <= next_rec.data;
		end else if (take_new) begin
			data_q <= new_rec.data;
		end else if (take_prev) begin
			data_q <= prev_rec.data;
		end
	end

endmodule
`default_nettype wire
